// ===== hw/rtl/xor_checksum_line_checker_core_assert.svh =====
// ----------------------------------------------------------------------------
// xor checksum line checker assertion macros
// concurrent assertion wrappers clocked on i_clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKSUM_LINE_CHECKER_CORE_ASSERT_SVH
`define XOR_CHECKSUM_LINE_CHECKER_CORE_ASSERT_SVH

// same-cycle implication
`define XCL_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define XCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/xcl_pkg.sv =====
// ----------------------------------------------------------------------------
// xcl_pkg
// types and constants shared by the xor checksum line checker
// ----------------------------------------------------------------------------
package xcl_pkg;

    localparam logic [7:0] FRAME_CHAR_RESET = 8'd36;
    localparam logic [7:0] STAR_CHAR        = 8'd42;
    localparam logic [7:0] PLUS_CHAR        = 8'd43;
    localparam logic [7:0] MINUS_CHAR       = 8'd45;
    localparam logic [7:0] ZERO_CHAR        = 8'd48;
    localparam logic [7:0] NINE_CHAR        = 8'd57;
    localparam logic [7:0] SPACE_CHAR       = 8'd32;
    localparam logic [7:0] TAB_CHAR         = 8'd9;
    localparam logic [7:0] CR_CHAR          = 8'd13;
    localparam logic [8:0] SUM_MAX          = 9'd255;
    localparam logic [8:0] SUM_SATURATED    = 9'd256;

    localparam logic [1:0] ST_CHECKED_OK = 2'd0;
    localparam logic [1:0] ST_NO_SUM     = 2'd1;
    localparam logic [1:0] ST_NO_START   = 2'd2;
    localparam logic [1:0] ST_MISMATCH   = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_PAY,
        PH_LEAD,
        PH_DIGITS,
        PH_STOP
    } t_phase;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic       resend_request;
        logic [7:0] computed_checksum;
        logic [8:0] received_checksum;
    } t_out_item;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] xor_acc;
        logic [8:0] digit_value;
        logic       negative_seen;
        logic       value_overflow;
    } t_line_state;

    localparam t_line_state LINE_STATE_RESET = '{
        phase:          PH_HUNT,
        xor_acc:        8'd0,
        digit_value:    9'd0,
        negative_seen:  1'b0,
        value_overflow: 1'b0
    };

endpackage

// ===== hw/rtl/xcl_in_stage.sv =====
// ----------------------------------------------------------------------------
// xcl_in_stage
// input register holding one byte item until the step logic consumes it
// ----------------------------------------------------------------------------
module xcl_in_stage
    import xcl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    // free slot, or the held item leaves this cycle
    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/xcl_step.sv =====
// ----------------------------------------------------------------------------
// xcl_step
// per-byte line state update and end-of-line verdict
// ----------------------------------------------------------------------------
module xcl_step
    import xcl_pkg::*;
(
    input  t_line_state i_state,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [7:0]  i_frame_char,
    output t_line_state o_state_next,
    output t_out_item   o_result
);

    t_line_state w_upd;
    logic        w_is_digit;
    logic        w_is_space;
    logic [11:0] w_times_ten;
    logic [11:0] w_digit_sum;
    logic [8:0]  w_received;
    logic [1:0]  w_status;
    logic [7:0]  w_computed;

    assign w_is_digit  = i_byte inside {[ZERO_CHAR:NINE_CHAR]};
    assign w_is_space  = i_byte inside {SPACE_CHAR, [TAB_CHAR:CR_CHAR]};
    // value * 10 as two shifted adds
    assign w_times_ten = ({3'd0, i_state.digit_value} << 3) + ({3'd0, i_state.digit_value} << 1);
    assign w_digit_sum = w_times_ten + {8'd0, i_byte[3:0]};

    always_comb begin
        w_upd = i_state;
        case (i_state.phase)
            PH_HUNT: begin
                if (i_byte == i_frame_char) begin
                    w_upd.phase = PH_PAY;
                end
            end
            PH_PAY: begin
                if (i_byte == STAR_CHAR) begin
                    w_upd.phase = PH_LEAD;
                end else begin
                    w_upd.xor_acc = i_state.xor_acc ^ i_byte;
                end
            end
            PH_LEAD, PH_DIGITS: begin
                if (w_is_digit) begin
                    w_upd.phase = PH_DIGITS;
                    if (!i_state.value_overflow) begin
                        if (w_digit_sum > {3'd0, SUM_MAX}) begin
                            w_upd.value_overflow = 1'b1;
                            w_upd.digit_value    = SUM_SATURATED;
                        end else begin
                            w_upd.digit_value = w_digit_sum[8:0];
                        end
                    end
                end else if (i_state.phase == PH_DIGITS) begin
                    w_upd.phase = PH_STOP;
                end else if (w_is_space) begin
                    w_upd.phase = PH_LEAD;
                end else if (i_byte == PLUS_CHAR) begin
                    w_upd.phase = PH_DIGITS;
                end else if (i_byte == MINUS_CHAR) begin
                    w_upd.phase         = PH_DIGITS;
                    w_upd.negative_seen = 1'b1;
                end else begin
                    w_upd.phase = PH_STOP;
                end
            end
            default: begin
                w_upd = i_state;
            end
        endcase
    end

    // negative nonzero or overflowed value reads as saturated
    assign w_received = (w_upd.value_overflow ||
                         (w_upd.negative_seen && (w_upd.digit_value != 9'd0))) ?
                        SUM_SATURATED : w_upd.digit_value;

    always_comb begin
        w_computed = w_upd.xor_acc;
        case (w_upd.phase)
            PH_HUNT: begin
                w_status   = ST_NO_START;
                w_computed = 8'd0;
            end
            PH_PAY: begin
                w_status = ST_NO_SUM;
            end
            default: begin
                w_status = (w_received == {1'b0, w_upd.xor_acc}) ? ST_CHECKED_OK : ST_MISMATCH;
            end
        endcase
    end

    always_comb begin
        o_result.status            = w_status;
        o_result.resend_request    = (w_status == ST_NO_START) || (w_status == ST_MISMATCH);
        o_result.computed_checksum = w_computed;
        o_result.received_checksum = ((w_status == ST_NO_START) || (w_status == ST_NO_SUM)) ?
                                     9'd0 : w_received;
    end

    assign o_state_next = i_last ? LINE_STATE_RESET : w_upd;

endmodule

// ===== hw/rtl/xcl_out_stage.sv =====
// ----------------------------------------------------------------------------
// xcl_out_stage
// result register presenting one verdict item to the consumer
// ----------------------------------------------------------------------------
module xcl_out_stage
    import xcl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_item,
    output logic      o_can_load,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_can_load) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/xor_checksum_line_checker_core.sv =====
// an accepted item waits in the input register and is processed from there; a line's
// verdict is loaded into the result register as its last byte leaves the input register
// throughput: one byte item per cycle, set by the state update loop, except that
// a line-end byte waits in the input register while the verdict register is stalled
// reset: synchronous active low; clears line state, stage valid bits, start char to '$'
// ----------------------------------------------------------------------------
// xor_checksum_line_checker_core
// byte-serial line checker: xor of payload after the start char, decimal
// checksum after '*', one verdict item per line
// ----------------------------------------------------------------------------
`include "xor_checksum_line_checker_core_assert.svh"

module xor_checksum_line_checker_core
    import xcl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    // verdict output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item,
    // start char register
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    // start char register
    logic [7:0]  r_frame_char;
    logic [7:0]  n_frame_char;

    // running line state, advanced once per consumed byte
    t_line_state r_state;
    t_line_state n_state;
    t_line_state w_step_state;

    // input register outputs
    logic        w_in_valid;
    t_in_item    w_in_item;

    // step logic verdict and output stage handshake
    t_out_item   w_result;
    logic        w_out_can_load;
    logic        w_advance;

    // a byte leaves the input register unless it ends a line and the
    // result register is still full and stalled
    assign w_advance = w_in_valid && (!w_in_item.line_end || w_out_can_load);

    xcl_in_stage u_in_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_item   (i_in_item),
        .i_advance(w_advance),
        .o_valid  (w_in_valid),
        .o_item   (w_in_item)
    );

    xcl_step u_step (
        .i_state     (r_state),
        .i_byte      (w_in_item.line_byte),
        .i_last      (w_in_item.line_end),
        .i_frame_char(r_frame_char),
        .o_state_next(w_step_state),
        .o_result    (w_result)
    );

    xcl_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_advance && w_in_item.line_end),
        .i_item    (w_result),
        .o_can_load(w_out_can_load),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (o_out_item)
    );

    always_comb begin
        n_state      = r_state;
        n_frame_char = r_frame_char;
        if (w_advance) begin
            n_state = w_step_state;
        end
        if (i_cfg_we) begin
            n_frame_char = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= LINE_STATE_RESET;
            r_frame_char <= FRAME_CHAR_RESET;
        end else begin
            r_state      <= n_state;
            r_frame_char <= n_frame_char;
        end
    end

    // ---- assertions ----

    // resend flag follows the verdict code
    `XCL_ASSERT_IMPLY(a_resend_matches_status, o_out_valid,
        o_out_item.resend_request == ((o_out_item.status == ST_NO_START) ||
                                      (o_out_item.status == ST_MISMATCH)),
        "resend flag disagrees with status")

    // a line without a start char carries zero checksums
    `XCL_ASSERT_IMPLY(a_no_start_zero, o_out_valid && (o_out_item.status == ST_NO_START),
        (o_out_item.computed_checksum == 8'd0) && (o_out_item.received_checksum == 9'd0),
        "no-start verdict with nonzero checksum fields")

    // while hunting, nothing has been accumulated or parsed
    `XCL_ASSERT_IMPLY(a_hunt_state_clear, r_state.phase == PH_HUNT,
        (r_state.xor_acc == 8'd0) && (r_state.digit_value == 9'd0) &&
        !r_state.negative_seen && !r_state.value_overflow,
        "line state not clear while hunting")

    // a consumed line-end byte always returns the parser to hunting
    `XCL_ASSERT_NEXT(a_line_end_resets, w_advance && w_in_item.line_end,
        r_state.phase == PH_HUNT,
        "parser did not return to hunting after line end")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the xor checksum line checker: framed, truncated and
// noisy lines go in byte by byte under several start chars, and every verdict
// is compared against an independent line-state predictor
// ----------------------------------------------------------------------------
module tb_top
    import xcl_pkg::*;
;

    // ------------------------------------------------------------------------
    // line predictor and verdict store
    // ------------------------------------------------------------------------
    class verdict_board;
        logic [7:0]  frame_char;
        t_phase      ph;
        logic [7:0]  xor_sum;
        logic [8:0]  parsed;
        logic        minus_seen;
        logic        saturated;
        t_out_item   want_q[$];
        int unsigned failures;
        int unsigned checked;
        int unsigned by_status[4];

        function new();
            frame_char = FRAME_CHAR_RESET;
            failures   = 0;
            checked    = 0;
            foreach (by_status[k]) by_status[k] = 0;
            clear_line();
        endfunction

        function void clear_line();
            ph         = PH_HUNT;
            xor_sum    = 8'd0;
            parsed     = 9'd0;
            minus_seen = 1'b0;
            saturated  = 1'b0;
        endfunction

        // decimal accumulate, pinned at 256 once past 255
        function void add_digit(logic [7:0] b);
            int unsigned acc;
            if (!saturated) begin
                acc = 32'(parsed) * 10 + 32'(b - ZERO_CHAR);
                if (acc > 32'(SUM_MAX)) begin
                    saturated = 1'b1;
                    parsed    = SUM_SATURATED;
                end else begin
                    parsed = acc[8:0];
                end
            end
        endfunction

        // advance line state by one accepted byte, queue a verdict at line end
        function void absorb_byte(t_in_item it);
            logic [7:0] b;
            logic [8:0] recv;
            t_out_item  v;
            b = it.line_byte;
            case (ph)
                PH_HUNT: begin
                    if (b == frame_char) ph = PH_PAY;
                end
                PH_PAY: begin
                    if (b == STAR_CHAR) ph = PH_LEAD;
                    else xor_sum ^= b;
                end
                PH_LEAD: begin
                    if (!(b == SPACE_CHAR || (b >= TAB_CHAR && b <= CR_CHAR))) begin
                        if (b == PLUS_CHAR) begin
                            ph = PH_DIGITS;
                        end else if (b == MINUS_CHAR) begin
                            minus_seen = 1'b1;
                            ph = PH_DIGITS;
                        end else if (b >= ZERO_CHAR && b <= NINE_CHAR) begin
                            add_digit(b);
                            ph = PH_DIGITS;
                        end else begin
                            ph = PH_STOP;
                        end
                    end
                end
                PH_DIGITS: begin
                    if (b >= ZERO_CHAR && b <= NINE_CHAR) add_digit(b);
                    else ph = PH_STOP;
                end
                default: ;
            endcase
            if (!it.line_end) return;

            v = '0;
            if (ph == PH_HUNT) begin
                v.status = ST_NO_START;
            end else if (ph == PH_PAY) begin
                v.status            = ST_NO_SUM;
                v.computed_checksum = xor_sum;
            end else begin
                recv = (saturated || (minus_seen && parsed != 9'd0)) ? SUM_SATURATED : parsed;
                v.computed_checksum = xor_sum;
                v.received_checksum = recv;
                v.status = (recv == {1'b0, xor_sum}) ? ST_CHECKED_OK : ST_MISMATCH;
            end
            v.resend_request = (v.status == ST_NO_START || v.status == ST_MISMATCH);
            want_q.push_back(v);
            clear_line();
        endfunction

        function void compare_verdict(t_out_item got);
            t_out_item want;
            if (want_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: verdict with none pending: st=%0d rs=%0d cs=%0d rx=%0d",
                             $time, got.status, got.resend_request,
                             got.computed_checksum, got.received_checksum);
                return;
            end
            want = want_q.pop_front();
            checked++;
            by_status[want.status]++;
            if (got.status != want.status || got.resend_request != want.resend_request ||
                got.computed_checksum != want.computed_checksum ||
                got.received_checksum != want.received_checksum) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: verdict %0d: expected st=%0d rs=%0d cs=%0d rx=%0d, got st=%0d rs=%0d cs=%0d rx=%0d",
                             $time, checked, want.status, want.resend_request,
                             want.computed_checksum, want.received_checksum,
                             got.status, got.resend_request,
                             got.computed_checksum, got.received_checksum);
            end
        endfunction

        function int unsigned pending();
            return want_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, dut, bench state
    // ------------------------------------------------------------------------
    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    verdict_board board = new();

    logic [7:0]  line_buf[$];
    logic        calm = 1'b0;    // no idling on either side while set
    int unsigned bytes_sent = 0;
    int unsigned lines_sent = 0;
    int unsigned chars_tried = 0;

    always #1 i_clk = ~i_clk;

    xor_checksum_line_checker_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // receiver stalls about 19 percent of the time unless calm is set
    always @(negedge i_clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= 19);
    end

    // verdicts are taken at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) board.compare_verdict(out_item);
    end

    // ------------------------------------------------------------------------
    // drive tasks, all entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_byte(input t_in_item it);
        while (!calm && $urandom_range(0, 99) < 19) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
        board.absorb_byte(it);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line();
        t_in_item it;
        foreach (line_buf[k]) begin
            it.line_byte = line_buf[k];
            it.line_end  = (k == line_buf.size() - 1);
            send_byte(it);
        end
        lines_sent++;
    endtask

    task automatic send_str(input string s);
        line_buf.delete();
        for (int k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
        send_line();
    endtask

    // hold off input until every verdict is out and the pipe has settled
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_frame_char(input logic [7:0] c);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        board.frame_char = c;
        chars_tried++;
    endtask

    function automatic logic [7:0] byte_other_than(input logic [7:0] x);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == x);
        return b;
    endfunction

    task automatic push_decimal(input int unsigned v, input int unsigned zeros);
        string s;
        s = $sformatf("%0d", v);
        repeat (zeros) line_buf.push_back(ZERO_CHAR);
        for (int k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
    endtask

    // junk, start char, payload, then usually a star and a checksum field
    task automatic build_framed_line();
        logic [7:0]  b;
        logic [7:0]  sum;
        int unsigned pick;
        int unsigned ws;
        line_buf.delete();
        sum = 8'd0;
        repeat ($urandom_range(0, 2)) line_buf.push_back(byte_other_than(board.frame_char));
        line_buf.push_back(board.frame_char);
        repeat ($urandom_range(0, 6)) begin
            b = byte_other_than(STAR_CHAR);
            sum ^= b;
            line_buf.push_back(b);
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) return;   // no checksum field at all

        line_buf.push_back(STAR_CHAR);
        repeat ($urandom_range(0, 2)) begin
            ws = $urandom_range(0, 5);
            line_buf.push_back(ws == 5 ? SPACE_CHAR : TAB_CHAR + 8'(ws));
        end
        if (pick < 70) begin
            if ($urandom_range(0, 3) == 0) line_buf.push_back(PLUS_CHAR);
            push_decimal(sum, $urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : 0);
        end else if (pick < 80) begin
            push_decimal($urandom_range(0, 999), 0);
        end else if (pick < 86) begin
            line_buf.push_back(MINUS_CHAR);
            push_decimal($urandom_range(0, 300), 0);
        end else if (pick < 92) begin
            // negative zero, sign alone, or nothing after the star
            case ($urandom_range(0, 2))
                0: begin
                    line_buf.push_back(MINUS_CHAR);
                    line_buf.push_back(ZERO_CHAR);
                end
                1: line_buf.push_back($urandom_range(0, 1) ? PLUS_CHAR : MINUS_CHAR);
                default: ;
            endcase
        end else begin
            push_decimal(sum ^ (8'd1 << $urandom_range(0, 7)), 0);
        end

        // trailing bytes after the number, led by a non-digit
        if ($urandom_range(0, 9) < 3) begin
            do b = 8'($urandom_range(0, 255)); while (b >= ZERO_CHAR && b <= NINE_CHAR);
            line_buf.push_back(b);
            repeat ($urandom_range(0, 2)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_random_line();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 90) begin
            build_framed_line();
            // cut short: missing star, checksum or tail
            if (pick >= 80 && line_buf.size() > 1)
                repeat ($urandom_range(1, line_buf.size() - 1)) void'(line_buf.pop_back());
        end else begin
            line_buf.delete();
            repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        send_line();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0]  phase_chars[6];
        int unsigned phase_base;
        logic        paused;

        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 8'd0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines under the default '$'
        write_frame_char(FRAME_CHAR_RESET);
        send_str("$");             // line ends on the start char
        line_buf = '{8'h00};       // no start char, zero byte
        send_line();
        send_str("$*0");
        send_str("$*-0");          // negative zero
        send_str("$*-5");          // negative nonzero saturates
        send_str("$* +");          // whitespace and a lone sign
        send_str("$$**");          // repeated start char and star
        line_buf = '{8'h24, 8'hFF, STAR_CHAR, 8'h39, 8'h39, 8'h39};
        send_line();               // value above 255
        wait_drained();

        phase_chars = '{8'd0, 8'd255, STAR_CHAR, 8'($urandom_range(0, 255)),
                        FRAME_CHAR_RESET, 8'($urandom_range(0, 255))};
        foreach (phase_chars[p]) begin
            write_frame_char(phase_chars[p]);
            calm       = (p == 2);
            phase_base = bytes_sent;
            paused     = 1'b0;
            while (bytes_sent - phase_base < 255) begin
                send_random_line();
                // mid-phase hold-off until the checker has caught up
                if (p == 1 && !paused && bytes_sent - phase_base >= 128) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            wait_drained();
        end
        calm = 1'b0;
        repeat (10) @(posedge i_clk);

        $display("sent %0d lines / %0d bytes under %0d start char settings",
                 lines_sent, bytes_sent, chars_tried);
        $display("verdicts: %0d ok, %0d no checksum, %0d no start, %0d mismatch",
                 board.by_status[ST_CHECKED_OK], board.by_status[ST_NO_SUM],
                 board.by_status[ST_NO_START], board.by_status[ST_MISMATCH]);
        if (board.pending() != 0)
            $display("%0d expected verdicts never arrived", board.pending());
        if (board.failures == 0 && board.pending() == 0) begin
            $display("[xor_checksum_line_checker_core] OK");
        end else begin
            $display("%0d failures", board.failures);
            $display("[xor_checksum_line_checker_core] ERROR");
        end
        $finish;
    end

    // hang guard
    initial begin
        #2_000_000;
        $display("timeout with %0d verdicts pending", board.pending());
        $display("[xor_checksum_line_checker_core] ERROR");
        $finish;
    end

endmodule

// ===== xor_checksum_line_checker_core.f =====
+incdir+hw/rtl
hw/rtl/xcl_pkg.sv
hw/rtl/xcl_in_stage.sv
hw/rtl/xcl_step.sv
hw/rtl/xcl_out_stage.sv
hw/rtl/xor_checksum_line_checker_core.sv
tb/sv/tb_top.sv
